// ===== hdl/rcn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_pkg: shared types and constants for the nearest segment hit ray caster
// holds the queue word layout, state encodings and the cordic angle table
// ----------------------------------------------------------------------------
package rcn_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned EdgeW       = 10;   // edge index, wraps at 1024
  localparam int unsigned QDepth      = 2;
  localparam logic [30:0] RangeReset  = 31'd655360;

  // front end states
  typedef enum logic [1:0] {
    F_IDLE,
    F_ROT,
    F_PUSH
  } f_state_e;

  // back end states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV,
    B_FIN
  } b_state_e;

  // one queue word: segment plus the ray it belongs to
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [17:0] dcos;
    logic signed [17:0] dsin;
    logic               first;
    logic               last;
  } seg_word_t;

  // arctangent table at a 32-bit angle scale
  function automatic logic signed [33:0] atan_at(input logic [4:0] k);
    logic signed [33:0] v;
    case (k)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // round to q1.16 and clamp to the unit range
  function automatic logic signed [17:0] round_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [17:0] o;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) begin
      o = 18'sd65536;
    end else if (r < -34'sd65536) begin
      o = -18'sd65536;
    end else begin
      o = r[17:0];
    end
    return o;
  endfunction

endpackage

// ===== hdl/rcn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_front: input side of the ray caster
// takes segment words, runs the cordic for a new ray and feeds the queue
// ----------------------------------------------------------------------------
module rcn_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic signed [31:0]       ray_x_i,
  input  logic signed [31:0]       ray_y_i,
  input  logic [15:0]              heading_i,
  input  logic [15:0]              beam_offset_i,
  input  logic signed [31:0]       seg_ax_i,
  input  logic signed [31:0]       seg_ay_i,
  input  logic signed [31:0]       seg_bx_i,
  input  logic signed [31:0]       seg_by_i,
  input  logic                     first_i,
  input  logic                     last_i,
  input  logic                     q_full_i,
  output logic                     q_wr_o,
  output rcn_pkg::seg_word_t       q_data_o
);

  rcn_pkg::f_state_e state_q, state_d;

  logic signed [31:0] ox_q, oy_q;
  logic signed [17:0] cos_q, sin_q;
  rcn_pkg::seg_word_t hold_q;
  logic signed [33:0] cx_q, sy_q, z_q;
  logic [4:0]         k_q;
  logic               flip_q;

  logic [15:0]        ang;
  logic signed [33:0] z0, zf;
  logic               flip0;
  logic signed [33:0] tx, ty;
  logic signed [17:0] rc, rs, dir_c, dir_s;
  logic               take;

  // beam angle to 32-bit scale, folded into the right half plane
  always_comb begin
    ang   = heading_i + beam_offset_i;
    z0    = {{2{ang[15]}}, ang, 16'h0000};
    zf    = z0;
    flip0 = 1'b0;
    if (z0 > 34'sd1073741824) begin
      zf    = z0 - 34'sd2147483648;
      flip0 = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      zf    = z0 + 34'sd2147483648;
      flip0 = 1'b1;
    end
  end

  // rotation step terms
  assign tx = sy_q >>> k_q;
  assign ty = cx_q >>> k_q;

  // rounded direction once rotation is done
  always_comb begin
    rc    = rcn_pkg::round_unit(cx_q);
    rs    = rcn_pkg::round_unit(sy_q);
    dir_c = flip_q ? -rc : rc;
    dir_s = flip_q ? -rs : rs;
  end

  assign full_o = (state_q != rcn_pkg::F_IDLE) || q_full_i;
  assign take   = push_i && !full_o;

  // next state and queue write
  always_comb begin
    state_d  = state_q;
    q_wr_o   = 1'b0;
    q_data_o = hold_q;
    case (state_q)
      rcn_pkg::F_IDLE: begin
        q_data_o.ax    = seg_ax_i;
        q_data_o.ay    = seg_ay_i;
        q_data_o.bx    = seg_bx_i;
        q_data_o.by    = seg_by_i;
        q_data_o.ox    = ox_q;
        q_data_o.oy    = oy_q;
        q_data_o.dcos  = cos_q;
        q_data_o.dsin  = sin_q;
        q_data_o.first = first_i;
        q_data_o.last  = last_i;
        if (take) begin
          if (first_i) begin
            state_d = rcn_pkg::F_ROT;
          end else begin
            q_wr_o = 1'b1;
          end
        end
      end
      rcn_pkg::F_ROT: begin
        if (k_q == 5'(rcn_pkg::CordicSteps - 1)) begin
          state_d = rcn_pkg::F_PUSH;
        end
      end
      rcn_pkg::F_PUSH: begin
        // new ray origin was latched when the word was taken
        q_data_o.ox   = ox_q;
        q_data_o.oy   = oy_q;
        q_data_o.dcos = dir_c;
        q_data_o.dsin = dir_s;
        if (!q_full_i) begin
          q_wr_o  = 1'b1;
          state_d = rcn_pkg::F_IDLE;
        end
      end
      default: state_d = rcn_pkg::F_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcn_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ray registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      cos_q <= '0;
      sin_q <= '0;
    end else begin
      if (state_q == rcn_pkg::F_IDLE && take && first_i) begin
        ox_q <= ray_x_i;
        oy_q <= ray_y_i;
      end
      if (state_q == rcn_pkg::F_PUSH && !q_full_i) begin
        cos_q <= dir_c;
        sin_q <= dir_s;
      end
    end
  end

  // held word and cordic iteration
  always_ff @(posedge clk_i) begin
    if (state_q == rcn_pkg::F_IDLE) begin
      hold_q <= q_data_o;
      cx_q   <= 34'sd652032874;
      sy_q   <= '0;
      z_q    <= zf;
      flip_q <= flip0;
      k_q    <= '0;
    end else if (state_q == rcn_pkg::F_ROT) begin
      if (!z_q[33]) begin
        cx_q <= cx_q - tx;
        sy_q <= sy_q + ty;
        z_q  <= z_q - rcn_pkg::atan_at(k_q);
      end else begin
        cx_q <= cx_q + tx;
        sy_q <= sy_q - ty;
        z_q  <= z_q + rcn_pkg::atan_at(k_q);
      end
      k_q <= k_q + 5'd1;
    end
  end

  // checks
  a_dir_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cos_q <= 18'sd65536) && (cos_q >= -18'sd65536)
    && (sin_q <= 18'sd65536) && (sin_q >= -18'sd65536))
    else $error("direction out of unit range");
  a_rot_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcn_pkg::F_ROT) |-> (k_q < 5'(rcn_pkg::CordicSteps)))
    else $error("rotation overran");
  a_no_write_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcn_pkg::F_ROT) |-> !q_wr_o)
    else $error("queue written during rotation");

endmodule

// ===== hdl/rcn_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_fifo: short word queue between front and back
// decouples classification from the arithmetic so each side stalls alone
// ----------------------------------------------------------------------------
module rcn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  rcn_pkg::seg_word_t wdata_i,
  output logic               full_o,
  input  logic               rd_i,
  output rcn_pkg::seg_word_t rdata_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = $clog2(rcn_pkg::QDepth);

  rcn_pkg::seg_word_t mem_q [rcn_pkg::QDepth];
  logic [PtrW-1:0]    wp_q, rp_q;
  logic [PtrW:0]      cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(rcn_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd_i && !empty_o) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW + 1)'(wr_i && !full_o) - (PtrW + 1)'(rd_i && !empty_o);
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW + 1)'(rcn_pkg::QDepth))
    else $error("queue count overflow");
  a_full_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && wr_i && !rd_i) |=> full_o)
    else $error("queue lost full");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wp_q == rp_q))
    else $error("queue pointers disagree");

endmodule

// ===== hdl/rcn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_back: segment test and running minimum
// shared multiplier over six products, restoring divider, result register
// ----------------------------------------------------------------------------
module rcn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [30:0]        range_i,
  input  logic               q_empty_i,
  input  rcn_pkg::seg_word_t q_data_i,
  output logic               q_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [30:0]        hit_distance_o,
  output logic signed [10:0] hit_edge_o
);

  rcn_pkg::b_state_e state_q, state_d;

  logic signed [32:0] ex_q, ey_q, wx_q, wy_q;
  logic signed [17:0] cos_q, sin_q;
  logic               last_q;
  logic [rcn_pkg::EdgeW-1:0] idx_q, cnt_q;
  logic [2:0]         s_q;
  logic signed [65:0] prod_q;
  logic signed [51:0] den_q, nv_q;
  logic signed [66:0] nu_q;
  logic [81:0]        rem_q, dsh_q;
  logic [30:0]        quo_q;
  logic [4:0]         dc_q;
  logic [30:0]        best_q;
  logic signed [10:0] edge_q;
  logic               out_v_q;

  logic signed [32:0] ma, mb;
  logic [2:0]         sp;
  logic               dneg, hit, ge, slot;
  logic signed [51:0] dn, vv;
  logic signed [66:0] nn;
  logic [30:0]        qn;

  assign slot    = !out_v_q || pop_i;
  assign empty_o = !out_v_q;
  assign q_rd_o  = (state_q == rcn_pkg::B_IDLE) && !q_empty_i;
  assign sp      = s_q - 3'd1;

  // multiplier operand select
  always_comb begin
    case (s_q)
      3'd0:    begin ma = ey_q;        mb = 33'(cos_q); end
      3'd1:    begin ma = ex_q;        mb = 33'(sin_q); end
      3'd2:    begin ma = ex_q;        mb = wy_q;       end
      3'd3:    begin ma = ey_q;        mb = wx_q;       end
      3'd4:    begin ma = 33'(cos_q);  mb = wy_q;       end
      3'd5:    begin ma = 33'(sin_q);  mb = wx_q;       end
      default: begin ma = '0;          mb = '0;         end
    endcase
  end

  // sign fold and hit test
  always_comb begin
    dneg = den_q[51];
    dn   = dneg ? -den_q : den_q;
    nn   = dneg ? -nu_q : nu_q;
    vv   = dneg ? -nv_q : nv_q;
    hit  = (den_q != '0) && !nn[66] && !vv[51] && (vv <= dn)
           && (nn < $signed({dn[51:0], 15'h0000}));
  end

  // divider step
  assign ge = rem_q >= dsh_q;
  assign qn = {quo_q[29:0], ge};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcn_pkg::B_IDLE: if (!q_empty_i) state_d = rcn_pkg::B_MUL;
      rcn_pkg::B_MUL:  if (s_q == 3'd6) state_d = rcn_pkg::B_CHK;
      rcn_pkg::B_CHK:  state_d = hit ? rcn_pkg::B_DIV : rcn_pkg::B_FIN;
      rcn_pkg::B_DIV:  if (dc_q == '0) state_d = rcn_pkg::B_FIN;
      rcn_pkg::B_FIN:  if (!last_q || slot) state_d = rcn_pkg::B_IDLE;
      default:         state_d = rcn_pkg::B_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcn_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // running minimum, edge count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      edge_q  <= -11'sd1;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && pop_i) begin
        out_v_q <= 1'b0;
      end
      if (q_rd_o) begin
        if (q_data_i.first) begin
          best_q <= range_i;
          edge_q <= -11'sd1;
          cnt_q  <= rcn_pkg::EdgeW'(1);
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == rcn_pkg::B_DIV && dc_q == '0 && qn < best_q) begin
        best_q <= qn;
        edge_q <= $signed({1'b0, idx_q});
      end
      if (state_q == rcn_pkg::B_FIN && last_q && slot) begin
        out_v_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      ex_q   <= 33'(q_data_i.bx) - 33'(q_data_i.ax);
      ey_q   <= 33'(q_data_i.by) - 33'(q_data_i.ay);
      wx_q   <= 33'(q_data_i.ox) - 33'(q_data_i.ax);
      wy_q   <= 33'(q_data_i.oy) - 33'(q_data_i.ay);
      cos_q  <= q_data_i.dcos;
      sin_q  <= q_data_i.dsin;
      last_q <= q_data_i.last;
      idx_q  <= q_data_i.first ? '0 : cnt_q;
      s_q    <= '0;
    end
    if (state_q == rcn_pkg::B_MUL) begin
      prod_q <= ma * mb;
      s_q    <= s_q + 3'd1;
      if (s_q != 3'd0) begin
        case (sp)
          3'd0:    den_q <= prod_q[51:0];
          3'd1:    den_q <= den_q - prod_q[51:0];
          3'd2:    nu_q  <= 67'(prod_q);
          3'd3:    nu_q  <= nu_q - 67'(prod_q);
          3'd4:    nv_q  <= prod_q[51:0];
          3'd5:    nv_q  <= nv_q - prod_q[51:0];
          default: ;
        endcase
      end
    end
    if (state_q == rcn_pkg::B_CHK) begin
      rem_q <= {nn[65:0], 16'h0000};
      dsh_q <= {dn[51:0], 30'h0};
      dc_q  <= 5'd30;
    end
    if (state_q == rcn_pkg::B_DIV) begin
      rem_q <= ge ? rem_q - dsh_q : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= qn;
      dc_q  <= dc_q - 5'd1;
    end
    if (state_q == rcn_pkg::B_FIN && last_q && slot) begin
      hit_distance_o <= best_q;
      hit_edge_o     <= edge_q;
    end
  end

  // checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |=> (out_v_q && $stable(hit_distance_o) && $stable(hit_edge_o)))
    else $error("result overwritten before taken");
  a_rd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> (state_q == rcn_pkg::B_MUL))
    else $error("queue read outside idle");
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_q == -11'sd1) || (edge_q >= 11'sd0))
    else $error("bad edge index");

endmodule

// ===== hdl/ray_cast_nearest_segment_hit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cast_nearest_segment_hit: nearest wall hit along one laser ray
// cordic direction front end, queue, multiply and divide back end
// ----------------------------------------------------------------------------
// channel   | handshake              | word
// segments  | push_i / full_o        | ray, angles, segment endpoints, first, last
// results   | pop_i / empty_o        | hit_distance_o, hit_edge_o
// config    | cfg_valid_i / cfg_ready_o | cfg_data_i (sensor range)
//
// a segment passes through multiply, check and finish in the back end; a hit
// candidate also runs 31 restoring divide steps; one multiplier is shared six ways
// a word with first holds full_o high in the front end through 24 cordic
// steps and one queue write
// reset clears all control state; the range register resets to 10.0
// a full result register stalls the back end, a full queue stalls input
// ----------------------------------------------------------------------------
module ray_cast_nearest_segment_hit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [31:0] ray_x_i,
  input  logic signed [31:0] ray_y_i,
  input  logic [15:0]        heading_i,
  input  logic [15:0]        beam_offset_i,
  input  logic signed [31:0] seg_ax_i,
  input  logic signed [31:0] seg_ay_i,
  input  logic signed [31:0] seg_bx_i,
  input  logic signed [31:0] seg_by_i,
  input  logic               first_i,
  input  logic               last_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [30:0]        hit_distance_o,
  output logic signed [10:0] hit_edge_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i
);

  logic [30:0]        range_q;
  logic               q_wr, q_full, q_rd, q_empty;
  rcn_pkg::seg_word_t q_wdata, q_rdata;

  // sensor range register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= rcn_pkg::RangeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      range_q <= cfg_data_i;
    end
  end

  rcn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .ray_x_i       (ray_x_i),
    .ray_y_i       (ray_y_i),
    .heading_i     (heading_i),
    .beam_offset_i (beam_offset_i),
    .seg_ax_i      (seg_ax_i),
    .seg_ay_i      (seg_ay_i),
    .seg_bx_i      (seg_bx_i),
    .seg_by_i      (seg_by_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .q_full_i      (q_full),
    .q_wr_o        (q_wr),
    .q_data_o      (q_wdata)
  );

  rcn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  rcn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .range_i        (range_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_rd_o         (q_rd),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .hit_distance_o (hit_distance_o),
    .hit_edge_o     (hit_edge_o)
  );

endmodule
